// ===== rtl/sine_eased_voltage_ramp_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sine eased voltage ramp
// Shared concurrent check wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINE_EASED_VOLTAGE_RAMP_TOP_DEFINES_SVH
`define SINE_EASED_VOLTAGE_RAMP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SEVR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sevr check failed");
`define SEVR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sevr check failed");
`else
`define SEVR_ASSERT(lbl, prop)
`define SEVR_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/sevr_pkg.sv =====
// ----------------------------------------------------------------------------
// sevr_pkg
// Types, constants and the quarter sine table for the voltage ramper.
// ----------------------------------------------------------------------------
`default_nettype none

package sevr_pkg;

  localparam int unsigned MAX_STEPS        = 64;
  localparam int unsigned SINE_ENTRIES     = 256;
  localparam int unsigned FULL_SCALE_VOLTS = 3000;
  localparam int unsigned DAC_MAX          = 255;

  localparam int unsigned ACT_W     = 2;
  localparam int unsigned VOLT_W    = 12;
  localparam int unsigned STEP_W    = 12;
  localparam int unsigned DAC_W     = 8;
  localparam int unsigned SINE_W    = 16;
  localparam int unsigned SINE_FRAC = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_RESET = 10;
  localparam int unsigned CMD_DEPTH  = 2;

  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned M_PAD_W  = M_DATA_W - DAC_W - VOLT_W - 1;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_UP_STEP   = 2'd0,
    CFG_RAMP_DOWN_STEP = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_RAMP_UP,
    CMD_RAMP_DOWN,
    CMD_STAT_ON,
    CMD_STAT_OFF
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [VOLT_W-1:0]  target;
    logic [STEP_W-1:0]  step;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_N_START,
    ST_N_WAIT,
    ST_IDX_START,
    ST_IDX_WAIT,
    ST_MUL,
    ST_OFF,
    ST_DAC_START
  } back_state_e;

  typedef logic [SINE_W-1:0] sine_tbl_t [SINE_ENTRIES+1];

  // Q30 Taylor series, rounded to Q1.15; evaluated at elaboration only
  function automatic logic [SINE_W-1:0] sine_q15(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    r = (64'(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return r[SINE_W-1:0];
  endfunction

  function automatic sine_tbl_t sine_table();
    sine_tbl_t t;
    for (int unsigned k = 0; k <= SINE_ENTRIES; k++) t[k] = sine_q15(k);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_eased_voltage_ramp_top.sv =====
// ----------------------------------------------------------------------------
// sine_eased_voltage_ramp_top
// High-voltage setpoint ramper with quarter-sine easing and DAC code output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tdata = action[1:0], target_voltage[13:2].
//   m_axis carries ramp points: tdata = dac_code[7:0], ramp_voltage[19:8],
//   hv_enable[20]; tlast marks the final point of a request's run.
//   cfg writes the step registers (index 0 ramp up, 1 ramp down); write only
//   while the block is idle. cfg_ready_o is always high.
// Ramp points: each point waits on the 15-bit serial divider that forms the
//   sine index; the DAC code is a reciprocal multiply in the output step.
// Status items go straight to the output register without a division; a zero
//   step register skips only the point-count division.
// Reset: present voltage 0 V, supply off, both steps 10 V, queue empty.
// Stall: a held output stalls the sequencer only once its next point is ready;
//   command queue keeps taking requests until full, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_eased_voltage_ramp_top #(
  parameter int unsigned MaxSteps = sevr_pkg::MAX_STEPS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // action[1:0], target_voltage[13:2], zero pad
  input  wire logic [sevr_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // dac_code[7:0], ramp_voltage[19:8], hv_enable[20], zero pad
  output logic [sevr_pkg::M_DATA_W-1:0]       m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sevr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sevr_pkg::STEP_W-1:0]    cfg_data_i
);

  import sevr_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);

  logic            push;
  cmd_t            push_data;
  logic            full;
  logic            pop;
  logic [CmdW-1:0] pop_data;
  logic            empty;

  sevr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  sevr_fifo #(
    .Width(CmdW),
    .Depth(CMD_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(CmdW'(push_data)),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  sevr_back #(
    .MaxSteps(MaxSteps)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_o          (pop),
    .pop_data_i     (cmd_t'(pop_data)),
    .empty_i        (empty),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sevr_fifo.sv =====
// ----------------------------------------------------------------------------
// sevr_fifo
// Short command queue between the classifier and the ramp sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_eased_voltage_ramp_top_defines.svh"

module sevr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      pop_data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    else if (pop_i && !push_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `SEVR_ASSERT(a_no_overflow, push_i |-> !full_o)
  `SEVR_ASSERT(a_no_underflow, pop_i |-> !empty_o)
  `SEVR_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ===== rtl/sevr_front.sv =====
// ----------------------------------------------------------------------------
// sevr_front
// Input side: step registers, request classification, command push.
// ----------------------------------------------------------------------------
`default_nettype none

module sevr_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [sevr_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sevr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sevr_pkg::STEP_W-1:0]   cfg_data_i,
  output logic                               push_o,
  output sevr_pkg::cmd_t                     push_data_o,
  input  wire logic                          full_i
);

  import sevr_pkg::*;

  logic              accept;
  logic              en_q, en_d;
  logic [STEP_W-1:0] up_step_q;
  logic [STEP_W-1:0] down_step_q;
  logic [VOLT_W-1:0] tgt_raw;
  logic [VOLT_W-1:0] tgt_sat;
  logic              push;

  assign s_axis_tready_o = !full_i;
  assign cfg_ready_o     = 1'b1;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign tgt_raw         = s_axis_tdata_i[ACT_W +: VOLT_W];
  assign tgt_sat         = (tgt_raw > VOLT_W'(FULL_SCALE_VOLTS)) ?
                           VOLT_W'(FULL_SCALE_VOLTS) : tgt_raw;
  assign push_o          = accept && push;

  always_comb begin
    push        = 1'b0;
    en_d        = en_q;
    push_data_o = '{kind: CMD_RAMP_UP, target: tgt_sat, step: up_step_q};
    case (action_e'(s_axis_tdata_i[ACT_W-1:0]))
      ACT_SET: begin
        push = en_q;
      end
      ACT_ON: begin
        push             = 1'b1;
        push_data_o.kind = CMD_STAT_ON;
        en_d             = 1'b1;
      end
      ACT_OFF: begin
        push               = 1'b1;
        push_data_o.kind   = en_q ? CMD_RAMP_DOWN : CMD_STAT_OFF;
        push_data_o.target = '0;
        push_data_o.step   = down_step_q;
        en_d               = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (accept) begin
      en_q <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_step_q   <= STEP_W'(STEP_RESET);
      down_step_q <= STEP_W'(STEP_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RAMP_UP_STEP:   up_step_q   <= cfg_data_i;
        CFG_RAMP_DOWN_STEP: down_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sevr_div.sv =====
// ----------------------------------------------------------------------------
// sevr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sevr_div #(
  parameter int unsigned Width = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] num_i,
  input  wire logic [Width-1:0] den_i,
  output logic                  done_o,
  output logic [Width-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q;
  logic [Width-1:0] quo_q;
  logic [Width-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Width);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[Width-1:0] : shifted[Width-1:0];
      quo_q <= {quo_q[Width-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sevr_back.sv =====
// ----------------------------------------------------------------------------
// sevr_back
// Ramp sequencer: point count, sine index, offset, DAC code, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_eased_voltage_ramp_top_defines.svh"

module sevr_back #(
  parameter int unsigned MaxSteps = sevr_pkg::MAX_STEPS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               pop_o,
  input  wire sevr_pkg::cmd_t                pop_data_i,
  input  wire logic                          empty_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [sevr_pkg::M_DATA_W-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  import sevr_pkg::*;

  localparam int unsigned NW       = $clog2(MaxSteps + 1);
  localparam int unsigned IdxW     = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned IdxNumW  = $clog2(2 * MaxSteps * SINE_ENTRIES);
  localparam int unsigned DacNumW  = $clog2(FULL_SCALE_VOLTS * DAC_MAX + 1);
  localparam int unsigned DivW     = (IdxNumW > VOLT_W) ? IdxNumW : VOLT_W;
  localparam int unsigned ProdW    = VOLT_W + SINE_W;
  localparam int unsigned OffW     = ProdW + 1 - SINE_FRAC;
  localparam sine_tbl_t   SineTbl  = sine_table();

  // DAC code by reciprocal: volts * (DAC_MAX * ceil(2^DacShift / FULL_SCALE_VOLTS))
  localparam int unsigned DacShift = DacNumW + $clog2(FULL_SCALE_VOLTS);
  localparam int unsigned DacKW    = DacNumW + 1 + DAC_W;
  localparam int unsigned DacProdW = VOLT_W + DacKW;
  localparam logic [DacKW-1:0] DacK =
    DacKW'((((64'd1 << DacShift) + 64'(FULL_SCALE_VOLTS) - 64'd1) /
            64'(FULL_SCALE_VOLTS)) * 64'(DAC_MAX));

  back_state_e       state_q, state_d;
  logic              m_valid_q, m_valid_d;
  logic [VOLT_W-1:0] pv_q, pv_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     i_q, i_d;

  cmd_kind_e         kind_q, kind_d;
  logic [VOLT_W-1:0] tgt_q, tgt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [VOLT_W-1:0] mag_q, mag_d;
  logic              rising_q, rising_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [VOLT_W-1:0] v_q, v_d;
  logic [DAC_W-1:0]  dac_o_q, dac_o_d;
  logic [VOLT_W-1:0] volt_o_q, volt_o_d;
  logic              en_o_q, en_o_d;
  logic              last_o_q, last_o_d;

  logic                div_start;
  logic [DivW-1:0]     div_num;
  logic [DivW-1:0]     div_den;
  logic                div_done;
  logic [DivW-1:0]     div_quot;
  logic                out_load;
  logic                status;
  logic                is_last;
  logic [NW-1:0]       nm1;
  logic [ProdW:0]      rnd;
  logic [OffW-1:0]     off_full;
  logic [VOLT_W-1:0]   off;
  logic [DacProdW-1:0] dac_prod;
  logic [DAC_W-1:0]    dac_code;

  sevr_div #(
    .Width(DivW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign status   = (kind_q == CMD_STAT_ON) || (kind_q == CMD_STAT_OFF);
  assign nm1      = n_q - NW'(1);
  assign is_last  = status || (i_q == nm1);
  assign rnd      = {1'b0, prod_q} + (ProdW + 1)'(1 << (SINE_FRAC - 1));
  assign off_full = rnd[ProdW:SINE_FRAC];
  assign off      = (off_full > OffW'(mag_q)) ? mag_q : off_full[VOLT_W-1:0];
  assign dac_prod = DacProdW'(v_q) * DacProdW'(DacK);
  assign dac_code = dac_prod[DacShift +: DAC_W];

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, en_o_q, volt_o_q, dac_o_q};
  assign m_axis_tlast_o  = last_o_q;

  always_comb begin
    state_d    = state_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    pv_d       = pv_q;
    n_d        = n_q;
    i_d        = i_q;
    kind_d     = kind_q;
    tgt_d      = tgt_q;
    step_d     = step_q;
    mag_d      = mag_q;
    rising_d   = rising_q;
    idx_d      = idx_q;
    prod_d     = prod_q;
    v_d        = v_q;
    dac_o_d    = dac_o_q;
    volt_o_d   = volt_o_q;
    en_o_d     = en_o_q;
    last_o_d   = last_o_q;
    pop_o      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          kind_d   = pop_data_i.kind;
          tgt_d    = pop_data_i.target;
          step_d   = pop_data_i.step;
          rising_d = (pop_data_i.target >= pv_q);
          mag_d    = (pop_data_i.target >= pv_q) ? pop_data_i.target - pv_q :
                                                   pv_q - pop_data_i.target;
          i_d      = '0;
          if (pop_data_i.kind == CMD_STAT_ON || pop_data_i.kind == CMD_STAT_OFF) begin
            v_d     = pv_q;
            state_d = ST_DAC_START;
          end else begin
            state_d = ST_N_START;
          end
        end
      end
      ST_N_START: begin
        if (step_q == '0) begin
          n_d     = NW'(MaxSteps);
          state_d = ST_IDX_START;
        end else begin
          div_start = 1'b1;
          div_num   = DivW'(mag_q);
          div_den   = DivW'(step_q);
          state_d   = ST_N_WAIT;
        end
      end
      ST_N_WAIT: begin
        if (div_done) begin
          if (div_quot < DivW'(2)) n_d = NW'(2);
          else if (div_quot > DivW'(MaxSteps)) n_d = NW'(MaxSteps);
          else n_d = div_quot[NW-1:0];
          state_d = ST_IDX_START;
        end
      end
      ST_IDX_START: begin
        div_start = 1'b1;
        div_num   = DivW'(i_q) * DivW'(2 * SINE_ENTRIES) + DivW'(nm1);
        div_den   = DivW'({nm1, 1'b0});
        state_d   = ST_IDX_WAIT;
      end
      ST_IDX_WAIT: begin
        if (div_done) begin
          idx_d   = (div_quot > DivW'(SINE_ENTRIES)) ? IdxW'(SINE_ENTRIES) :
                                                      div_quot[IdxW-1:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(mag_q) * ProdW'(SineTbl[idx_q]);
        state_d = ST_OFF;
      end
      ST_OFF: begin
        v_d     = rising_q ? pv_q + off : pv_q - off;
        state_d = ST_DAC_START;
      end
      ST_DAC_START: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          m_valid_d = 1'b1;
          dac_o_d   = dac_code;
          volt_o_d  = v_q;
          last_o_d  = is_last;
          en_o_d    = status ? (kind_q == CMD_STAT_ON) :
                               (is_last ? (kind_q == CMD_RAMP_UP) : 1'b1);
          if (is_last) begin
            state_d = ST_IDLE;
            if (!status) pv_d = tgt_q;
          end else begin
            i_d     = i_q + NW'(1);
            state_d = ST_IDX_START;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      pv_q       <= '0;
      n_q        <= NW'(2);
      i_q        <= '0;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      pv_q       <= pv_d;
      n_q        <= n_d;
      i_q        <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    tgt_q    <= tgt_d;
    step_q   <= step_d;
    mag_q    <= mag_d;
    rising_q <= rising_d;
    idx_q    <= idx_d;
    prod_q   <= prod_d;
    v_q      <= v_d;
    dac_o_q  <= dac_o_d;
    volt_o_q <= volt_o_d;
    en_o_q   <= en_o_d;
    last_o_q <= last_o_d;
  end

  `SEVR_ASSERT(a_n_range, (state_q == ST_IDX_START) |-> (n_q >= NW'(2) && i_q < n_q))
  `SEVR_ASSERT(a_volt_range, m_valid_q |-> (volt_o_q <= VOLT_W'(FULL_SCALE_VOLTS)))
  `SEVR_ASSERT(a_last_hits_target, (out_load && is_last && !status) |-> (v_q == tgt_q))

endmodule

`default_nettype wire
